[rtl/core/bba_pkg.sv]
// Shared constants, opcodes and interface structs for the bitmap block allocator.
// No dependencies; bba_map and bitmap_block_allocator import this package.
package bba_pkg;

  // Store geometry.
  localparam int NUM_BLOCKS  = 256;
  localparam int BLOCK_BYTES = 256;

  // Field widths of the stream items.
  localparam int OP_W   = 3;
  localparam int IDX_W  = 8;
  localparam int OFF_W  = 8;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 9;

  // Derived widths.
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int DATA_DEPTH = NUM_BLOCKS * BLOCK_BYTES;
  localparam int ADDR_W     = $clog2(DATA_DEPTH);

  // The bitmap is searched as groups, with a registered full flag per group.
  localparam int GRP_BITS  = 32;
  localparam int NUM_GRP   = NUM_BLOCKS / GRP_BITS;
  localparam int GSEL_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int BSEL_W    = $clog2(GRP_BITS);

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_BITS   = OP_W + IDX_W + OFF_W + BYTE_W;
  localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + IDX_W + BYTE_W + CNT_W + CNT_W;
  localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd0;
  localparam logic [OP_W-1:0] OP_CLAIM    = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ     = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd4;

  // Request handed from the input stage to the bitmap unit.
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  blk;
    logic [OFF_W-1:0]  off;
  } map_req_t;

  // Decision returned by the bitmap unit for the same cycle.
  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  blk_out;
    logic              rd_en;
    logic              wr_en;
    logic [CNT_W-1:0]  used;
  } map_rsp_t;

endpackage

[rtl/core/bba_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bba_map.sv]
// Allocation bitmap, used-block counter and request decision logic.
// Depends on bba_pkg.
module bba_map
  import bba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  map_req_t req,
  output map_rsp_t rsp
);

  logic [NUM_BLOCKS-1:0] map_r, map_nxt;
  logic [NUM_GRP-1:0]    grp_full_r, grp_full_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;

  logic                  any_free;
  logic [GSEL_W-1:0]     grp_sel;
  logic [GRP_BITS-1:0]   grp_bits;
  logic [BSEL_W-1:0]     bit_sel;
  logic [BLK_W-1:0]      free_idx;

  logic                  blk_valid;
  logic                  off_valid;
  logic                  cur_alloc;

  // Lowest group that still has a free block, then the lowest free bit in it.
  always_comb begin
    any_free = 1'b0;
    grp_sel  = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (!grp_full_r[g]) begin
        any_free = 1'b1;
        grp_sel  = GSEL_W'(g);
      end
    end
  end

  assign grp_bits = map_r[grp_sel * GRP_BITS +: GRP_BITS];

  always_comb begin
    bit_sel = '0;
    for (int b = GRP_BITS - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bit_sel = BSEL_W'(b);
      end
    end
  end

  assign free_idx = BLK_W'({grp_sel, bit_sel});

  assign blk_valid = (32'(req.blk) < NUM_BLOCKS);
  assign off_valid = (32'(req.off) < BLOCK_BYTES);
  assign cur_alloc = map_r[req.blk[BLK_W-1:0]];

  always_comb begin
    map_nxt     = map_r;
    used_nxt    = used_r;
    rsp.ok      = 1'b0;
    rsp.blk_out = '0;
    rsp.rd_en   = 1'b0;
    rsp.wr_en   = 1'b0;
    case (req.op)
      OP_ALLOCATE: begin
        if (any_free) begin
          map_nxt[free_idx] = 1'b1;
          used_nxt          = used_r + 1'b1;
          rsp.ok            = 1'b1;
          rsp.blk_out       = IDX_W'(free_idx);
        end
      end
      OP_CLAIM: begin
        if (blk_valid && !cur_alloc) begin
          map_nxt[req.blk[BLK_W-1:0]] = 1'b1;
          used_nxt                    = used_r + 1'b1;
          rsp.ok                      = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (blk_valid) begin
          if (cur_alloc) begin
            map_nxt[req.blk[BLK_W-1:0]] = 1'b0;
            used_nxt                    = used_r - 1'b1;
          end
          rsp.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (blk_valid && off_valid && cur_alloc) begin
          rsp.rd_en = 1'b1;
          rsp.ok    = 1'b1;
        end
      end
      OP_WRITE: begin
        if (blk_valid && off_valid && cur_alloc) begin
          rsp.wr_en = 1'b1;
          rsp.ok    = 1'b1;
        end
      end
      default: begin
        rsp.ok = 1'b0;
      end
    endcase
    rsp.used = used_nxt;
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_full_nxt[g] = &map_nxt[g * GRP_BITS +: GRP_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r      <= '0;
      grp_full_r <= '0;
      used_r     <= '0;
    end else if (req.valid) begin
      map_r      <= map_nxt;
      grp_full_r <= grp_full_nxt;
      used_r     <= used_nxt;
    end
  end

endmodule

[rtl/core/bitmap_block_allocator.sv]
// Top level of the bitmap block allocator: input stage, result stage, data memory
// and the memory clearing pass. Depends on bba_pkg, bba_map and bba_ram.
//
// Each request beat gets exactly one result beat, and a new request can be taken every
// cycle while the result side is ready and no clearing pass runs. The request is
// registered, decided against the allocation bitmap, and the result is ready once
// the data memory's registered read returns. The block takes one more request
// while a result waits on the output. After reset the data memory is zeroed one
// byte per cycle, a pass over all NUM_BLOCKS * BLOCK_BYTES (65536) bytes, during
// which in_tready stays low.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: req_type[2:0], block_index[10:3], byte_offset[18:11],
  // write_byte[26:19], zero fill above.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,
  // out_tdata: ok[0], block_out[8:1], read_byte[16:9], used_count[25:17],
  // free_count[34:26], zero fill above.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata
);

  // Input stage.
  logic              v0_r, v0_nxt;
  logic [OP_W-1:0]   op0_r;
  logic [IDX_W-1:0]  blk0_r;
  logic [OFF_W-1:0]  off0_r;
  logic [BYTE_W-1:0] wb0_r;

  // Result stage.
  logic              v1_r, v1_nxt;
  logic              ok1_r;
  logic [IDX_W-1:0]  blk_out1_r;
  logic [CNT_W-1:0]  used1_r;
  logic              rd1_r;

  // Clearing pass.
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              in_fire;
  logic              adv1;
  logic              go0;

  map_req_t          req;
  map_rsp_t          rsp;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [BYTE_W-1:0] read_byte;
  logic [CNT_W-1:0]  free_count;

  assign adv1      = !v1_r || out_tready;
  assign go0       = v0_r && adv1;
  assign in_tready = !clr_busy_r && (!v0_r || adv1);
  assign in_fire   = in_tvalid && in_tready;

  assign v0_nxt = in_fire ? 1'b1 : (go0 ? 1'b0 : v0_r);
  assign v1_nxt = go0 ? 1'b1 : (out_tready ? 1'b0 : v1_r);

  assign req.valid = go0;
  assign req.op    = op0_r;
  assign req.blk   = blk0_r;
  assign req.off   = off0_r;

  bba_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign ram_addr = ADDR_W'(32'(blk0_r[BLK_W-1:0]) * BLOCK_BYTES + 32'(off0_r));

  // The clearing pass owns the write port until it finishes; no request is in
  // flight then because in_tready is held low.
  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = go0 && rsp.wr_en;
      ram_waddr = ram_addr;
      ram_wdata = wb0_r;
    end
  end

  assign ram_re = go0 && rsp.rd_en;

  bba_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DATA_DEPTH)
  ) u_data (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DATA_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      v0_r       <= v0_nxt;
      v1_r       <= v1_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op0_r  <= in_tdata[OP_W-1:0];
      blk0_r <= in_tdata[OP_W +: IDX_W];
      off0_r <= in_tdata[OP_W + IDX_W +: OFF_W];
      wb0_r  <= in_tdata[OP_W + IDX_W + OFF_W +: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (go0) begin
      ok1_r      <= rsp.ok;
      blk_out1_r <= rsp.blk_out;
      used1_r    <= rsp.used;
      rd1_r      <= rsp.rd_en;
    end
  end

  // The memory's read register only changes on a read, so it holds while the
  // result beat is stalled.
  assign read_byte  = rd1_r ? ram_rdata : '0;
  assign free_count = CNT_W'(NUM_BLOCKS) - used1_r;

  assign out_tvalid = v1_r;
  assign out_tdata  = OUT_TW'({free_count, used1_r, read_byte, blk_out1_r, ok1_r});

endmodule

[tb/tb_bitmap_block_allocator.sv]
// Self-checking testbench for bitmap_block_allocator: directed and random request streams
// with random idling on both sides, checked beat by beat against a built-in predictor.
// Depends on bba_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RESET_CYCLES = 8;
  localparam int TOTAL_REQUESTS = 750;
  localparam int RECENT_DEPTH = 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  blk;
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] wbyte;
  } alloc_req_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  blk_out;
    logic [BYTE_W-1:0] rbyte;
    logic [CNT_W-1:0]  used_cnt;
    logic [CNT_W-1:0]  free_cnt;
  } alloc_result_t;

  typedef enum {MIX_TRAFFIC, FILL_STORE, DRAIN_STORE} traffic_t;

  // Tracks the allocation bitmap, block bytes and used count, and holds
  // the results still owed by the block in request order.
  class alloc_scoreboard;
    bit [NUM_BLOCKS-1:0] taken;
    bit [BYTE_W-1:0]     store [DATA_DEPTH];
    int unsigned         used;
    int unsigned         mismatches;
    alloc_result_t       owed_q[$];

    function void note_request(alloc_req_t req);
      alloc_result_t res;
      bit blk_ok;
      bit off_ok;
      int unsigned addr;
      res = '0;
      blk_ok = int'(req.blk) < NUM_BLOCKS;
      off_ok = int'(req.off) < BLOCK_BYTES;
      addr = int'(req.blk) * BLOCK_BYTES + int'(req.off);
      case (req.op)
        OP_ALLOCATE: begin
          for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (!taken[i]) begin
              taken[i] = 1'b1;
              used++;
              res.ok = 1'b1;
              res.blk_out = IDX_W'(i);
              break;
            end
          end
        end
        OP_CLAIM: begin
          if (blk_ok && !taken[req.blk]) begin
            taken[req.blk] = 1'b1;
            used++;
            res.ok = 1'b1;
          end
        end
        OP_RELEASE: begin
          // Releasing a free block still succeeds.
          if (blk_ok) begin
            if (taken[req.blk]) begin
              taken[req.blk] = 1'b0;
              used--;
            end
            res.ok = 1'b1;
          end
        end
        OP_READ: begin
          if (blk_ok && off_ok && taken[req.blk]) begin
            res.rbyte = store[addr];
            res.ok = 1'b1;
          end
        end
        OP_WRITE: begin
          if (blk_ok && off_ok && taken[req.blk]) begin
            store[addr] = req.wbyte;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.used_cnt = CNT_W'(used);
      res.free_cnt = CNT_W'(NUM_BLOCKS - used);
      owed_q.push_back(res);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [OUT_TW-1:0] beat);
      alloc_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result beat with no request pending", beat[31:0], 0);
      end else begin
        want = owed_q.pop_front();
        if (beat[0] !== want.ok) report_mismatch("ok", beat[0], want.ok);
        if (beat[8:1] !== want.blk_out) report_mismatch("block_out", beat[8:1], want.blk_out);
        if (beat[16:9] !== want.rbyte) report_mismatch("read_byte", beat[16:9], want.rbyte);
        if (beat[25:17] !== want.used_cnt)
          report_mismatch("used_count", beat[25:17], want.used_cnt);
        if (beat[34:26] !== want.free_cnt)
          report_mismatch("free_count", beat[34:26], want.free_cnt);
      end
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  alloc_scoreboard sb;
  int unsigned     cycles = 0;
  int unsigned     sent = 0;
  bit              steady = 1'b0;
  logic [15:0]     recent_writes[$];

  bitmap_block_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[bitmap_block_allocator] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Mostly short gaps, now and then a long one; none while steady is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [IDX_W-1:0] pick_taken_block();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(NUM_BLOCKS - 1));
    if (sb.used == 0) return idx;
    while (!sb.taken[idx]) idx = IDX_W'($urandom_range(NUM_BLOCKS - 1));
    return idx;
  endfunction

  function automatic alloc_req_t make_request(traffic_t mode);
    alloc_req_t req;
    int r;
    logic [15:0] spot;
    req.op = OP_W'($urandom());
    req.blk = IDX_W'($urandom());
    req.off = OFF_W'($urandom());
    req.wbyte = BYTE_W'($urandom());
    r = $urandom_range(99);
    case (mode)
      FILL_STORE: begin
        if (r < 70) req.op = OP_ALLOCATE;
        else if (r < 80) req.op = OP_CLAIM;
        else if (r < 90) req.op = OP_WRITE;
        else req.op = OP_READ;
      end
      DRAIN_STORE: begin
        if (r < 70) req.op = OP_RELEASE;
        else if (r < 80) req.op = OP_READ;
        else if (r < 90) req.op = OP_WRITE;
        else if (r < 95) req.op = OP_ALLOCATE;
        else req.op = OP_W'($urandom_range(2**OP_W - 1, OP_WRITE + 1));
      end
      default: begin
        if (r < 15) req.op = OP_ALLOCATE;
        else if (r < 27) req.op = OP_CLAIM;
        else if (r < 40) req.op = OP_RELEASE;
        else if (r < 68) req.op = OP_READ;
        else if (r < 95) req.op = OP_WRITE;
        else req.op = OP_W'($urandom_range(2**OP_W - 1, OP_WRITE + 1));
      end
    endcase
    r = $urandom_range(99);
    case (req.op)
      OP_CLAIM: if (r < 30) req.blk = pick_taken_block();
      OP_RELEASE: if (r < 75) req.blk = pick_taken_block();
      OP_WRITE: begin
        if (r < 85) req.blk = pick_taken_block();
        recent_writes.push_back({req.blk, req.off});
        if (recent_writes.size() > RECENT_DEPTH) void'(recent_writes.pop_front());
      end
      OP_READ: begin
        // Reading back recent writes is what exposes data path errors.
        if (r < 40 && recent_writes.size() > 0) begin
          spot = recent_writes[$urandom_range(recent_writes.size() - 1)];
          req.blk = spot[15:8];
          req.off = spot[7:0];
        end else if (r < 90) begin
          req.blk = pick_taken_block();
        end
      end
      default: ;
    endcase
    return req;
  endfunction

  task automatic drive_request(alloc_req_t req);
    int gap;
    if (sent % 64 == 0) steady = ($urandom_range(3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= IN_TW'({req.wbyte, req.off, req.blk, req.op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req);
    sent++;
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] blk,
                         logic [OFF_W-1:0] off, logic [BYTE_W-1:0] wbyte);
    alloc_req_t req;
    req = '{op: op, blk: blk, off: off, wbyte: wbyte};
    drive_request(req);
  endtask

  initial begin : result_sink
    int stall;
    int burst;
    @(posedge rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      burst = steady ? 16 : $urandom_range(8, 1);
      repeat (burst - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: access to free blocks, first-free allocation, claim conflicts,
    // byte extremes, data kept across release, and the unused opcodes.
    send_op(OP_READ, 8'd0, 8'd0, 8'h00);
    send_op(OP_WRITE, 8'd0, 8'd0, 8'h5A);
    send_op(OP_RELEASE, 8'd5, 8'd0, 8'h00);
    send_op(OP_ALLOCATE, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_ALLOCATE, 8'd0, 8'd0, 8'd0);
    send_op(OP_CLAIM, 8'd255, 8'd0, 8'd0);
    send_op(OP_CLAIM, 8'd255, 8'd0, 8'd0);
    send_op(OP_CLAIM, 8'd1, 8'd0, 8'd0);
    send_op(OP_WRITE, 8'd255, 8'd255, 8'hFF);
    send_op(OP_WRITE, 8'd255, 8'd0, 8'hA5);
    send_op(OP_READ, 8'd255, 8'd255, 8'h00);
    send_op(OP_READ, 8'd255, 8'd0, 8'h00);
    send_op(OP_READ, 8'd1, 8'd128, 8'h00);
    send_op(OP_WRITE, 8'd0, 8'd128, 8'h00);
    send_op(OP_READ, 8'd0, 8'd128, 8'hFF);
    send_op(OP_RELEASE, 8'd255, 8'd0, 8'd0);
    send_op(OP_READ, 8'd255, 8'd255, 8'd0);
    send_op(OP_WRITE, 8'd255, 8'd255, 8'h11);
    send_op(OP_CLAIM, 8'd255, 8'd0, 8'd0);
    send_op(OP_READ, 8'd255, 8'd255, 8'd0);
    send_op(OP_RELEASE, 8'd0, 8'd0, 8'd0);
    send_op(OP_ALLOCATE, 8'd0, 8'd0, 8'd0);
    for (int op = OP_WRITE + 1; op < 2**OP_W; op++)
      send_op(OP_W'(op), IDX_W'($urandom()), OFF_W'($urandom()), BYTE_W'($urandom()));

    // Random: mixed traffic, then fill the store past full, drain it, mix again.
    while (sent < 200) drive_request(make_request(MIX_TRAFFIC));
    while (sb.used < NUM_BLOCKS) drive_request(make_request(FILL_STORE));
    repeat (24) drive_request(make_request(FILL_STORE));
    while (sb.used > 48 && sent < 700) drive_request(make_request(DRAIN_STORE));
    while (sent < TOTAL_REQUESTS) drive_request(make_request(MIX_TRAFFIC));

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_map.sv
rtl/core/bitmap_block_allocator.sv
tb/tb_bitmap_block_allocator.sv
